>>> rtl/rppe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rppe_pkg
// Shared types, codes and helpers of the ramp pair energy pipeline.
// ----------------------------------------------------------------------------
package rppe_pkg;

	localparam int NUM_TYPES_DEF = 4;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_EVAL  = 1'b1;

	localparam logic [2:0] SEL_SIGMA   = 3'd0;
	localparam logic [2:0] SEL_EPSILON = 3'd1;
	localparam logic [2:0] SEL_CUTOFF  = 3'd2;
	localparam logic [2:0] SEL_LAMBDA  = 3'd3;
	localparam logic [2:0] SEL_GAMMA   = 3'd4;

	localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	// parameters of one pair plus the region flags
	typedef struct packed {
		logic signed [31:0] sigma;
		logic signed [31:0] eps;
		logic signed [31:0] cut;
		logic signed [31:0] lam;
		logic signed [31:0] gam;
		logic               ovl;
		logic               inr;
	} pair_t;

	// flags that ride along the divider
	typedef struct packed {
		logic ovl;
		logic dzero;
		logic nzero;
		logic nneg;
		logic neg;
		logic ovf;
	} div_side_t;

	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
			return v[31:0];
		end
		return v[33] ? S32_MIN : S32_MAX;
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

endpackage
`default_nettype wire

>>> rtl/rppe_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rppe_sqrt
// Pipelined floor square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module rppe_sqrt #(
	parameter int DW = 48,
	parameter int PW = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_vld,
	input  wire logic [DW-1:0]         in_rad,
	input  wire logic [PW-1:0]         in_side,
	output logic                       out_vld,
	output logic [(DW+1)/2-1:0]        out_root,
	output logic [PW-1:0]              out_side
);
	localparam int RB   = (DW + 1) / 2;
	localparam int PADW = 2 * RB;

	logic            vld_s  [RB];
	logic [PADW-1:0] rad_s  [RB];
	logic [RB:0]     rem_s  [RB];
	logic [RB-1:0]   root_s [RB];
	logic [PW-1:0]   side_s [RB];

	for (genvar i = 0; i < RB; i++) begin : g_stage
		logic            p_vld;
		logic [PADW-1:0] p_rad;
		logic [RB:0]     p_rem;
		logic [RB-1:0]   p_root;
		logic [PW-1:0]   p_side;
		logic [RB+1:0]   cur;
		logic [RB+1:0]   trial;
		logic            take;

		if (i == 0) begin : g_first
			assign p_vld  = in_vld;
			assign p_rad  = PADW'(in_rad);
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_side = in_side;
		end else begin : g_next
			assign p_vld  = vld_s[i-1];
			assign p_rad  = rad_s[i-1];
			assign p_rem  = rem_s[i-1];
			assign p_root = root_s[i-1];
			assign p_side = side_s[i-1];
		end

		assign cur   = {p_rem[RB-1:0], p_rad[PADW-1 -: 2]};
		assign trial = {p_root, 2'b01};
		assign take  = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			rad_s[i]  <= p_rad << 2;
			rem_s[i]  <= take ? (RB+1)'(cur - trial) : (RB+1)'(cur);
			root_s[i] <= {p_root[RB-2:0], take};
			side_s[i] <= p_side;
		end
	end

	assign out_vld  = vld_s[RB-1];
	assign out_root = root_s[RB-1];
	assign out_side = side_s[RB-1];

endmodule
`default_nettype wire

>>> rtl/rppe_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rppe_div
// Pipelined restoring divider, 64 by 32 bits, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rppe_div #(
	parameter int PW = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_vld,
	input  wire logic [31:0]   in_hi,
	input  wire logic [31:0]   in_lo,
	input  wire logic [31:0]   in_den,
	input  wire logic [PW-1:0] in_side,
	output logic               out_vld,
	output logic [31:0]        out_q,
	output logic [PW-1:0]      out_side
);
	localparam int NS = 32;

	logic          vld_s  [NS];
	logic [31:0]   rem_s  [NS];
	logic [31:0]   lo_s   [NS];
	logic [31:0]   den_s  [NS];
	logic [31:0]   q_s    [NS];
	logic [PW-1:0] side_s [NS];

	for (genvar i = 0; i < NS; i++) begin : g_stage
		logic          p_vld;
		logic [31:0]   p_rem;
		logic [31:0]   p_lo;
		logic [31:0]   p_den;
		logic [31:0]   p_q;
		logic [PW-1:0] p_side;
		logic [32:0]   cur;
		logic          take;

		if (i == 0) begin : g_first
			assign p_vld  = in_vld;
			assign p_rem  = in_hi;
			assign p_lo   = in_lo;
			assign p_den  = in_den;
			assign p_q    = '0;
			assign p_side = in_side;
		end else begin : g_next
			assign p_vld  = vld_s[i-1];
			assign p_rem  = rem_s[i-1];
			assign p_lo   = lo_s[i-1];
			assign p_den  = den_s[i-1];
			assign p_q    = q_s[i-1];
			assign p_side = side_s[i-1];
		end

		assign cur  = {p_rem, p_lo[31]};
		assign take = (cur >= {1'b0, p_den});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i]  <= take ? 32'(cur - {1'b0, p_den}) : cur[31:0];
			lo_s[i]   <= p_lo << 1;
			den_s[i]  <= p_den;
			q_s[i]    <= {p_q[30:0], take};
			side_s[i] <= p_side;
		end
	end

	assign out_vld  = vld_s[NS-1];
	assign out_q    = q_s[NS-1];
	assign out_side = side_s[NS-1];

endmodule
`default_nettype wire

>>> rtl/ramp_pair_potential_energy.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ramp_pair_potential_energy
// Two-ramp core-softened pair energy with per-pair parameter tables.
// ----------------------------------------------------------------------------
// a request reaches done through the table and region stages, the one-bit-per-stage square root,
//   the operand, product and sign stages and the 32-stage divider (Q16.16 at FRAC_BITS = 16)
// throughput: one request per cycle, busy stays low, results are never held
// reset clears all valid bits; the parameter tables are not reset
module ramp_pair_potential_energy #(
	parameter int NUM_TYPES = rppe_pkg::NUM_TYPES_DEF,
	parameter int FRAC_BITS = rppe_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               kind,
	input  wire logic [1:0]         type_a,
	input  wire logic [1:0]         type_b,
	input  wire logic [2:0]         param_select,
	input  wire logic signed [31:0] param_value,
	input  wire logic [31:0]        dist_sq,
	output logic                    done,
	output logic signed [31:0]      energy,
	output logic                    overlap
);
	import rppe_pkg::*;

	localparam int DEPTH = NUM_TYPES * NUM_TYPES;
	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DW    = 32 + FRAC_BITS;
	localparam int RB    = (DW + 1) / 2;
	localparam int PPW   = $bits(pair_t);
	localparam int DPW   = $bits(div_side_t);

	logic signed [31:0] sigma_q   [DEPTH];
	logic signed [31:0] epsilon_q [DEPTH];
	logic signed [31:0] cutoff_q  [DEPTH];
	logic signed [31:0] lambda_q  [DEPTH];
	logic signed [31:0] gamma_q   [DEPTH];

	logic          accept;
	logic          wr_ok;
	logic [IW-1:0] widx;
	logic [IW-1:0] ridx;
	int            ta_e;
	int            tb_e;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign wr_ok  = accept && (kind == KIND_WRITE) && (int'(type_a) < NUM_TYPES)
		&& (int'(type_b) < NUM_TYPES);
	assign widx   = IW'(int'(type_a) * NUM_TYPES + int'(type_b));
	assign ta_e   = (int'(type_a) >= NUM_TYPES) ? NUM_TYPES - 1 : int'(type_a);
	assign tb_e   = (int'(type_b) >= NUM_TYPES) ? NUM_TYPES - 1 : int'(type_b);
	assign ridx   = IW'(ta_e * NUM_TYPES + tb_e);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			case (param_select)
				SEL_SIGMA:   sigma_q[widx]   <= param_value;
				SEL_EPSILON: epsilon_q[widx] <= param_value;
				SEL_CUTOFF:  cutoff_q[widx]  <= param_value;
				SEL_LAMBDA:  lambda_q[widx]  <= param_value;
				SEL_GAMMA:   gamma_q[widx]   <= param_value;
				default: ;
			endcase
		end
	end

	// stage 1: table lookup
	logic          vld_s1;
	logic [DW-1:0] d2w_s1;
	pair_t         pair_s1;

	// stage 2: squared sigma and lambda
	logic          vld_s2;
	logic [DW-1:0] d2w_s2;
	pair_t         pair_s2;
	logic [63:0]   sig_sq_s2;
	logic [63:0]   lam_sq_s2;

	// stage 3: region compares
	logic          vld_s3;
	logic [DW-1:0] d2w_s3;
	pair_t         pair_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept && (kind == KIND_EVAL);
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		d2w_s1        <= {dist_sq, FRAC_BITS'(0)};
		pair_s1.sigma <= sigma_q[ridx];
		pair_s1.eps   <= epsilon_q[ridx];
		pair_s1.cut   <= cutoff_q[ridx];
		pair_s1.lam   <= lambda_q[ridx];
		pair_s1.gam   <= gamma_q[ridx];
		pair_s1.ovl   <= 1'b0;
		pair_s1.inr   <= 1'b0;

		d2w_s2    <= d2w_s1;
		pair_s2   <= pair_s1;
		sig_sq_s2 <= mag32(pair_s1.sigma) * mag32(pair_s1.sigma);
		lam_sq_s2 <= mag32(pair_s1.lam) * mag32(pair_s1.lam);

		d2w_s3        <= d2w_s2;
		pair_s3.sigma <= pair_s2.sigma;
		pair_s3.eps   <= pair_s2.eps;
		pair_s3.cut   <= pair_s2.cut;
		pair_s3.lam   <= pair_s2.lam;
		pair_s3.gam   <= pair_s2.gam;
		pair_s3.ovl   <= {(64-DW)'(0), d2w_s2} < sig_sq_s2;
		pair_s3.inr   <= {(64-DW)'(0), d2w_s2} < lam_sq_s2;
	end

	logic           sq_vld;
	logic [RB-1:0]  sq_root;
	logic [PPW-1:0] sq_side_raw;
	pair_t          sq_side;

	rppe_sqrt #(
		.DW (DW),
		.PW (PPW)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s3),
		.in_rad   (d2w_s3),
		.in_side  (pair_s3),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side_raw)
	);

	assign sq_side = pair_t'(sq_side_raw);

	// stage 4: saturated differences and operand select
	logic signed [33:0] dist34;
	logic signed [33:0] sig34;
	logic signed [33:0] lam34;
	logic signed [33:0] cut34;

	assign dist34 = signed'({(34-RB)'(0), sq_root});
	assign sig34  = 34'(sq_side.sigma);
	assign lam34  = 34'(sq_side.lam);
	assign cut34  = 34'(sq_side.cut);

	logic               vld_s4;
	logic               ovl_s4;
	logic signed [31:0] x1_s4;
	logic signed [31:0] y1_s4;
	logic signed [31:0] x2_s4;
	logic signed [31:0] y2_s4;
	logic signed [31:0] den_s4;

	// stage 5: products
	logic               vld_s5;
	logic               ovl_s5;
	logic signed [63:0] p1_s5;
	logic signed [63:0] p2_s5;
	logic signed [31:0] den_s5;

	// stage 6: numerator
	logic               vld_s6;
	logic               ovl_s6;
	logic signed [64:0] num_s6;
	logic signed [31:0] den_s6;

	// stage 7: magnitudes and signs
	logic               vld_s7;
	logic               ovl_s7;
	logic [63:0]        nmag_s7;
	logic               nneg_s7;
	logic               nzero_s7;
	logic [31:0]        dmag_s7;
	logic               dneg_s7;
	logic               dzero_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s4 <= sq_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		ovl_s4 <= sq_side.ovl;
		x2_s4  <= sq_side.eps;
		if (sq_side.inr) begin
			// inner ramp: gamma*(lambda-r) - epsilon*(r-sigma)
			x1_s4  <= sq_side.gam;
			y1_s4  <= sat34(lam34 - dist34);
			y2_s4  <= sat34(dist34 - sig34);
			den_s4 <= sat34(lam34 - sig34);
		end else begin
			// outer ramp: -epsilon*(cutoff-r)
			x1_s4  <= '0;
			y1_s4  <= '0;
			y2_s4  <= sat34(cut34 - dist34);
			den_s4 <= sat34(cut34 - lam34);
		end

		ovl_s5 <= ovl_s4;
		p1_s5  <= x1_s4 * y1_s4;
		p2_s5  <= x2_s4 * y2_s4;
		den_s5 <= den_s4;

		ovl_s6 <= ovl_s5;
		num_s6 <= 65'(p1_s5) - 65'(p2_s5);
		den_s6 <= den_s5;

		ovl_s7   <= ovl_s6;
		nmag_s7  <= num_s6[64] ? 64'(-num_s6) : num_s6[63:0];
		nneg_s7  <= num_s6[64];
		nzero_s7 <= (num_s6 == '0);
		dmag_s7  <= mag32(den_s6);
		dneg_s7  <= den_s6[31];
		dzero_s7 <= (den_s6 == '0);
	end

	div_side_t      dv_in;
	logic           dv_vld;
	logic [31:0]    dv_q;
	logic [DPW-1:0] dv_side_raw;
	div_side_t      dv_side;

	always_comb begin
		dv_in.ovl   = ovl_s7;
		dv_in.dzero = dzero_s7;
		dv_in.nzero = nzero_s7;
		dv_in.nneg  = nneg_s7;
		dv_in.neg   = nneg_s7 ^ dneg_s7;
		// quotient would need more than 32 bits
		dv_in.ovf   = (nmag_s7[63:32] >= dmag_s7);
	end

	rppe_div #(
		.PW (DPW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s7),
		.in_hi    (nmag_s7[63:32]),
		.in_lo    (nmag_s7[31:0]),
		.in_den   (dmag_s7),
		.in_side  (dv_in),
		.out_vld  (dv_vld),
		.out_q    (dv_q),
		.out_side (dv_side_raw)
	);

	assign dv_side = div_side_t'(dv_side_raw);

	logic signed [31:0] energy_d;

	always_comb begin
		if (dv_side.ovl) begin
			energy_d = S32_MAX;
		end else if (dv_side.dzero) begin
			energy_d = dv_side.nzero ? '0 : (dv_side.nneg ? S32_MIN : S32_MAX);
		end else if (dv_side.ovf) begin
			energy_d = dv_side.neg ? S32_MIN : S32_MAX;
		end else if (dv_side.neg) begin
			energy_d = (dv_q > 32'h8000_0000) ? S32_MIN : signed'(32'(-dv_q));
		end else begin
			energy_d = (dv_q > 32'h7fff_ffff) ? S32_MAX : signed'(dv_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		energy  <= energy_d;
		overlap <= dv_side.ovl;
	end

`ifndef SYNTHESIS
	localparam int LAT = 40 + RB;

	a_eval_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_EVAL) |-> ##LAT done)
		else $error("evaluate request gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy && kind == KIND_EVAL) |-> ##LAT !done)
		else $error("result without evaluate request");

	a_overlap_max: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overlap) |-> (energy == S32_MAX))
		else $error("overlap result not saturated");
`endif

endmodule
`default_nettype wire
